>>> sv/dll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_pkg: shared types for the doubly linked list engine
// Operation codes, status codes, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package dll_pkg;

   typedef enum logic [2:0] {
      FUNC_APPEND   = 3'd0,
      FUNC_DEL_TAIL = 3'd1,
      FUNC_DEL_HEAD = 3'd2,
      FUNC_DEL_POS  = 3'd3,
      FUNC_FIND     = 3'd4,
      FUNC_EDIT     = 3'd5,
      FUNC_REVERSE  = 3'd6,
      FUNC_DUMP     = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_RANGE     = 3'd2,
      STAT_FULL      = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_VISIT,
      ST_UNLINK_P,
      ST_UNLINK_N,
      ST_APPEND_T,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request, start walk at head
      logic advance;     // move cursor to next node, bump index
      logic swap;        // reverse: swap links of current node, advance
      logic flip_ends;   // reverse: swap head and tail
      logic wr_value;    // edit: write value at current node
      logic alloc;       // append: write new node, update tail
      logic link_tail;   // append: old tail next -> new node
      logic unlink;      // delete: latch links of current node, free it
      logic fix_prev;    // delete: repair neighbor before
      logic fix_next;    // delete: repair neighbor after
      logic emit;        // present a result word
      logic emit_last;
      logic emit_data;   // result carries value and index
      status_type stat;
      logic at_tail;     // seek tail instead of walking
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      func_type func;
      logic     empty;
      logic     full;
      logic     pos_bad;   // position at or beyond count
      logic     at_pos;    // walk index equals requested position
      logic     match;     // current node value equals request value
      logic     walk_end;  // index reached count
      logic     last_elem; // index is count-1
   } sts_type;

endpackage

>>> sv/dll_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_ram: generic single-port-write, one-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module dll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> sv/dll_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_datapath: node store, list pointers and walk cursor
// Holds values and links in RAMs, head/tail/count/free map in flops.
// ----------------------------------------------------------------------------
module dll_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_func,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   input  dll_pkg::cmd_type   cmd,
   output dll_pkg::sts_type   sts,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_result_value,
   output logic [7:0]         rsp_result_position,
   output logic [8:0]         rsp_element_count,
   output logic               rsp_last,
   output logic               rsp_strobe
);
   localparam int AW = $clog2(CAPACITY);
   localparam int LW = AW + 1;          // link width, includes null marker
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [LW-1:0] NIL = LW'(CAPACITY);

   logic [LW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CAPACITY-1:0] free_ff, free_in;
   logic [2:0]     func_ff;
   logic [7:0]     pos_ff;
   logic [31:0]    val_ff;
   logic [LW-1:0]  cur_ff, cur_in;
   logic [8:0]     idx_ff, idx_in;
   logic [LW-1:0]  up_ff, dn_ff;       // unlinked node neighbors
   logic [AW-1:0]  alloc_idx;
   logic           alloc_ok;

   // RAM ports
   logic          v_we, n_we, p_we;
   logic [AW-1:0] v_wa, n_wa, p_wa, rd_a;
   logic [31:0]   v_wd, v_rd;
   logic [LW-1:0] n_wd, p_wd, n_rd, p_rd;

   dll_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
      .clock(clock), .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd),
      .rd_addr(rd_a), .rd_data(v_rd));
   dll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_addr(rd_a), .rd_data(n_rd));
   dll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(rd_a), .rd_data(p_rd));

   // lowest free node (priority encoder over the free map)
   always_comb begin
      alloc_idx = '0;
      alloc_ok  = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            alloc_idx = AW'(i);
            alloc_ok  = 1'b1;
         end
      end
   end

   assign rd_a = cur_ff[AW-1:0];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      free_in  = free_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      v_we = 1'b0; v_wa = cur_ff[AW-1:0]; v_wd = val_ff;
      n_we = 1'b0; n_wa = cur_ff[AW-1:0]; n_wd = NIL;
      p_we = 1'b0; p_wa = cur_ff[AW-1:0]; p_wd = NIL;
      if (cmd.load) begin
         cur_in = cmd.at_tail ? tail_ff : head_ff;
         idx_in = '0;
      end
      if (cmd.advance) begin
         cur_in = n_rd;
         idx_in = idx_ff + 9'd1;
      end
      if (cmd.swap) begin
         n_we = 1'b1; n_wd = p_rd;
         p_we = 1'b1; p_wd = n_rd;
         cur_in = n_rd;
         idx_in = idx_ff + 9'd1;
      end
      if (cmd.flip_ends) begin
         head_in = tail_ff;
         tail_in = head_ff;
      end
      if (cmd.wr_value) begin
         v_we = 1'b1;
      end
      if (cmd.alloc) begin
         v_we = 1'b1; v_wa = alloc_idx;
         n_we = 1'b1; n_wa = alloc_idx; n_wd = NIL;
         p_we = 1'b1; p_wa = alloc_idx; p_wd = tail_ff;
         free_in[alloc_idx] = 1'b0;
         tail_in  = LW'(alloc_idx);
         count_in = count_ff + CW'(1);
         cur_in   = tail_ff;          // old tail for the link step
         if (tail_ff == NIL) begin
            head_in = LW'(alloc_idx);
         end
      end
      // no old tail means the new node is also the head
      if (cmd.link_tail && cur_ff != NIL) begin
         n_we = 1'b1; n_wd = tail_ff;
      end
      if (cmd.unlink) begin
         free_in[cur_ff[AW-1:0]] = 1'b1;
         count_in = count_ff - CW'(1);
         if (p_rd == NIL) head_in = n_rd;
         if (n_rd == NIL) tail_in = p_rd;
         cur_in = p_rd;
      end
      // skip the repair on a side that has no neighbor
      if (cmd.fix_prev && up_ff != NIL) begin
         n_we = 1'b1; n_wa = up_ff[AW-1:0]; n_wd = dn_ff;
      end
      if (cmd.fix_next && dn_ff != NIL) begin
         p_we = 1'b1; p_wa = dn_ff[AW-1:0]; p_wd = up_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= NIL;
         tail_ff  <= NIL;
         count_ff <= '0;
         free_ff  <= '1;
         rsp_strobe <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         free_ff  <= free_in;
         rsp_strobe <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      // a tail seek reuses load; the request word is only taken on acceptance
      if (cmd.load && !cmd.at_tail) begin
         func_ff <= req_func;
         pos_ff  <= req_position;
         val_ff  <= req_value;
      end
      if (cmd.unlink) begin
         up_ff <= p_rd;
         dn_ff <= n_rd;
      end
      if (cmd.emit) begin
         rsp_status          <= cmd.stat;
         rsp_result_value    <= cmd.emit_data ? ((func_ff == 3'(dll_pkg::FUNC_FIND))
                                ? val_ff : v_rd) : '0;
         rsp_result_position <= cmd.emit_data ? idx_ff[7:0] : '0;
         rsp_element_count   <= 9'(count_in);
         rsp_last            <= cmd.emit_last;
      end
   end

   assign sts.func      = dll_pkg::func_type'(func_ff);
   assign sts.empty     = (count_ff == '0);
   assign sts.full      = !alloc_ok;
   assign sts.pos_bad   = (9'(pos_ff) >= 9'(count_ff));
   assign sts.at_pos    = (idx_ff == 9'(pos_ff));
   assign sts.match     = (v_rd == val_ff);
   assign sts.walk_end  = (idx_ff >= 9'(count_ff));
   assign sts.last_elem = (idx_ff + 9'd1 == 9'(count_ff));
endmodule

>>> sv/dll_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dll_ctrl: operation sequencer
// Steps the datapath through walks, link repairs and result words.
// ----------------------------------------------------------------------------
module dll_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dll_pkg::sts_type sts,
   output dll_pkg::cmd_type cmd
);
   dll_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dll_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.stat = dll_pkg::STAT_OK;
      busy     = (state_ff != dll_pkg::ST_IDLE);
      case (state_ff)
         dll_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = dll_pkg::ST_DECODE;
            end
         end
         dll_pkg::ST_DECODE: begin
            // func is captured; issue first read at head (delete tail reloads at tail)
            case (sts.func)
               dll_pkg::FUNC_APPEND: begin
                  if (sts.full) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1;
                     cmd.stat = dll_pkg::STAT_FULL;
                     state_in = dll_pkg::ST_DONE;
                  end else begin
                     cmd.alloc = 1'b1;
                     state_in  = dll_pkg::ST_APPEND_T;
                  end
               end
               dll_pkg::FUNC_DEL_TAIL, dll_pkg::FUNC_DEL_HEAD,
               dll_pkg::FUNC_DEL_POS: begin
                  if (sts.empty) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1;
                     cmd.stat = dll_pkg::STAT_EMPTY;
                     state_in = dll_pkg::ST_DONE;
                  end else if (sts.func == dll_pkg::FUNC_DEL_POS && sts.pos_bad) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1;
                     cmd.stat = dll_pkg::STAT_RANGE;
                     state_in = dll_pkg::ST_DONE;
                  end else begin
                     if (sts.func == dll_pkg::FUNC_DEL_TAIL) begin
                        cmd.load = 1'b1; cmd.at_tail = 1'b1;
                     end
                     state_in = dll_pkg::ST_READ;
                  end
               end
               dll_pkg::FUNC_EDIT: begin
                  if (sts.pos_bad) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1;
                     cmd.stat = dll_pkg::STAT_RANGE;
                     state_in = dll_pkg::ST_DONE;
                  end else begin
                     state_in = dll_pkg::ST_READ;
                  end
               end
               dll_pkg::FUNC_DUMP: begin
                  if (sts.empty) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1;
                     cmd.stat = dll_pkg::STAT_EMPTY;
                     state_in = dll_pkg::ST_DONE;
                  end else begin
                     state_in = dll_pkg::ST_READ;
                  end
               end
               default: state_in = dll_pkg::ST_READ;   // find, reverse
            endcase
         end
         dll_pkg::ST_READ: begin
            // RAM read of current node in flight
            state_in = dll_pkg::ST_VISIT;
         end
         dll_pkg::ST_VISIT: begin
            state_in = dll_pkg::ST_READ;
            case (sts.func)
               dll_pkg::FUNC_FIND: begin
                  if (sts.walk_end) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1;
                     cmd.stat = dll_pkg::STAT_NOT_FOUND;
                     state_in = dll_pkg::ST_DONE;
                  end else if (sts.match) begin
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1; cmd.emit_data = 1'b1;
                     state_in = dll_pkg::ST_DONE;
                  end else begin
                     cmd.advance = 1'b1;
                  end
               end
               dll_pkg::FUNC_REVERSE: begin
                  if (sts.walk_end) begin
                     cmd.flip_ends = 1'b1;
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1;
                     state_in = dll_pkg::ST_DONE;
                  end else begin
                     cmd.swap = 1'b1;
                  end
               end
               dll_pkg::FUNC_DUMP: begin
                  cmd.emit = 1'b1; cmd.emit_data = 1'b1;
                  if (sts.last_elem) begin
                     cmd.emit_last = 1'b1;
                     state_in = dll_pkg::ST_DONE;
                  end else begin
                     cmd.advance = 1'b1;
                  end
               end
               dll_pkg::FUNC_EDIT: begin
                  if (sts.at_pos) begin
                     cmd.wr_value = 1'b1;
                     cmd.emit = 1'b1; cmd.emit_last = 1'b1;
                     state_in = dll_pkg::ST_DONE;
                  end else begin
                     cmd.advance = 1'b1;
                  end
               end
               dll_pkg::FUNC_DEL_POS: begin
                  if (sts.at_pos) begin
                     cmd.unlink = 1'b1;
                     state_in = dll_pkg::ST_UNLINK_P;
                  end else begin
                     cmd.advance = 1'b1;
                  end
               end
               default: begin   // delete head or tail: cursor already there
                  cmd.unlink = 1'b1;
                  state_in = dll_pkg::ST_UNLINK_P;
               end
            endcase
         end
         dll_pkg::ST_UNLINK_P: begin
            cmd.fix_prev = sts.empty ? 1'b0 : 1'b1;
            state_in = dll_pkg::ST_UNLINK_N;
         end
         dll_pkg::ST_UNLINK_N: begin
            cmd.fix_next = 1'b1;
            cmd.emit = 1'b1; cmd.emit_last = 1'b1;
            state_in = dll_pkg::ST_DONE;
         end
         dll_pkg::ST_APPEND_T: begin
            cmd.link_tail = 1'b1;
            cmd.emit = 1'b1; cmd.emit_last = 1'b1;
            state_in = dll_pkg::ST_DONE;
         end
         dll_pkg::ST_DONE: begin
            state_in = dll_pkg::ST_IDLE;
         end
         default: state_in = dll_pkg::ST_IDLE;
      endcase
   end
endmodule

>>> sv/doubly_linked_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_engine: bounded doubly linked list of signed words
// Sequenced operations on a node store with value, next and prev RAMs.
// ----------------------------------------------------------------------------
// Pulse start with a request word while busy is low; busy rises on the next
// cycle and falls when the operation is complete. Every result word appears
// on the rsp_ ports for exactly one cycle with rsp_strobe high and cannot be
// held off, so capture it on that cycle; rsp_last marks the final word of a
// request. Append steps through decode, the tail link and wrap-up; delete
// head/tail through decode, a read of the node RAMs, a visit, the unlink
// states and wrap-up. Position walks, find, reverse and dump pass each node
// visited through a read state of the node RAMs and a visit state, between
// decode and wrap-up. Dump emits one word per node, from its visit state. A
// delete repairs each neighbor's link in a state of its own, prev then next.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_func,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_result_value,
   output logic [7:0]         rsp_result_position,
   output logic [8:0]         rsp_element_count,
   output logic               rsp_last
);
   dll_pkg::cmd_type cmd;
   dll_pkg::sts_type sts;

   // sequencer: owns busy, drives datapath commands
   dll_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .sts(sts), .cmd(cmd));

   // store, pointers, walk cursor and result register
   dll_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset),
      .req_func(req_func), .req_position(req_position), .req_value(req_value),
      .cmd(cmd), .sts(sts),
      .rsp_status(rsp_status), .rsp_result_value(rsp_result_value),
      .rsp_result_position(rsp_result_position),
      .rsp_element_count(rsp_element_count),
      .rsp_last(rsp_last), .rsp_strobe(rsp_strobe));

   // a result word only comes out of a request in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result word without a request in flight");

   // element count never exceeds capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_element_count <= 9'(CAPACITY))
      else $error("element count beyond capacity");

   // the final word of a request ends it
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("result word after the final word");
endmodule
